FILE: hw/rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

    // configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULL_UP  = 2'd0,
        CFG_DEBOUNCE = 2'd1,
        CFG_GAP      = 2'd2,
        CFG_LONG     = 2'd3
    } t_cfg_idx;

    // timer widths
    localparam int SINCE_W = 8;
    localparam int HOLD_W  = 16;
    localparam int GAP_W   = 16;
    localparam int CLICK_W = 8;

    // register reset values
    localparam logic               RST_PULL_UP  = 1'b1;
    localparam logic [SINCE_W-1:0] RST_DEBOUNCE = 8'd15;
    localparam logic [GAP_W-1:0]   RST_GAP      = 16'd400;
    localparam logic [HOLD_W-1:0]  RST_LONG     = 16'd1000;

    // one result item
    typedef struct packed {
        logic               pressed;
        logic               press_event;
        logic               release_event;
        logic               long_press;
        logic [CLICK_W-1:0] click_count;
        logic [HOLD_W-1:0]  hold_time;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/button_click_classifier_top.sv
// ----------------------------------------------------------------------------
// button_click_classifier_top
// Debounce, hold timing, long press and multi-click detection on a 1 ms tick.
// ----------------------------------------------------------------------------
// Each input item is one millisecond tick carrying the raw pin level. The
// block takes one item per clock cycle unless the result channel stalls, and
// returns exactly one result item per tick. An item waits in the input register; the
// classifier state advances as the item moves into the result register,
// where the result is held until it is taken. The result register and
// the input register together hold two items, so one more tick is taken
// while a finished result waits on i_out_ready. Configuration writes are
// taken at any time (o_cfg_ready is always high) and must be made while the
// block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_classifier_top
    import bcc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    // tick input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_pin_level,

    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_pressed,
    output logic                       o_press_event,
    output logic                       o_release_event,
    output logic                       o_long_press,
    output logic [CLICK_W-1:0]         o_click_count,
    output logic [HOLD_W-1:0]          o_hold_time
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic               r_pull_up;
    logic [SINCE_W-1:0] r_debounce;
    logic [GAP_W-1:0]   r_gap_limit;
    logic [HOLD_W-1:0]  r_long_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pull_up    <= RST_PULL_UP;
            r_debounce   <= RST_DEBOUNCE;
            r_gap_limit  <= RST_GAP;
            r_long_limit <= RST_LONG;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PULL_UP:  r_pull_up    <= i_cfg_data[0];
                CFG_DEBOUNCE: r_debounce   <= i_cfg_data[SINCE_W-1:0];
                CFG_GAP:      r_gap_limit  <= i_cfg_data[GAP_W-1:0];
                CFG_LONG:     r_long_limit <= i_cfg_data[HOLD_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: input register -> result register
    // ------------------------------------------------------------------
    logic    r_in_valid;
    logic    r_in_pin;
    logic    r_out_valid;
    t_result r_out;
    logic    w_adv;        // item moves from input register to result register

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_pin <= i_pin_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // classifier state
    // ------------------------------------------------------------------
    logic               r_stable,   n_stable;
    logic [SINCE_W-1:0] r_since,    n_since;
    logic               r_holding,  n_holding;
    logic [HOLD_W-1:0]  r_hold_tmr, n_hold_tmr;
    logic               r_gap_act,  n_gap_act;
    logic [GAP_W-1:0]   r_gap_tmr,  n_gap_tmr;
    logic [CLICK_W-1:0] r_clicks,   n_clicks;
    t_result            n_out;

    // one tick, in order: debounce, raw hold timing, long press, multiclick
    always_comb begin
        logic active;

        n_stable   = r_stable;
        n_since    = r_since;
        n_holding  = r_holding;
        n_hold_tmr = r_hold_tmr;
        n_gap_act  = r_gap_act;
        n_gap_tmr  = r_gap_tmr;
        n_clicks   = r_clicks;
        n_out      = '0;

        active = r_in_pin ^ r_pull_up;

        // debounce; saturating timer, counted before the compare
        if (n_since != '1) n_since = n_since + 1'b1;
        if ((active != n_stable) && (n_since > r_debounce)) begin
            n_stable = active;
            n_since  = '0;
            n_out.press_event   = active;
            n_out.release_event = !active;
        end

        // raw hold timing
        if (n_holding && (n_hold_tmr != '1)) n_hold_tmr = n_hold_tmr + 1'b1;
        if (active) begin
            if (!n_holding) begin
                n_holding  = 1'b1;
                n_hold_tmr = '0;
            end
            n_out.hold_time = n_hold_tmr;
        end

        // raw release ends the hold; a long one drops the click sequence
        if (!active && n_holding) begin
            if (n_hold_tmr > r_long_limit) begin
                n_out.long_press = 1'b1;
                n_gap_act = 1'b0;
                n_gap_tmr = '0;
                n_clicks  = '0;
            end
            n_holding  = 1'b0;
            n_hold_tmr = '0;
        end

        // multiclick gap and count
        if (n_gap_act && (n_gap_tmr != '1)) n_gap_tmr = n_gap_tmr + 1'b1;
        if (n_out.press_event) begin
            n_gap_act = 1'b1;
            n_gap_tmr = '0;
            if (n_clicks != '1) n_clicks = n_clicks + 1'b1;
        end
        if ((n_clicks != '0) && n_gap_act && (n_gap_tmr > r_gap_limit) &&
            !n_stable && !n_holding) begin
            n_out.click_count = n_clicks;
            n_clicks  = '0;
            n_gap_act = 1'b0;
            n_gap_tmr = '0;
        end

        n_out.pressed = n_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable   <= 1'b0;
            r_since    <= '0;
            r_holding  <= 1'b0;
            r_hold_tmr <= '0;
            r_gap_act  <= 1'b0;
            r_gap_tmr  <= '0;
            r_clicks   <= '0;
        end else if (w_adv) begin
            r_stable   <= n_stable;
            r_since    <= n_since;
            r_holding  <= n_holding;
            r_hold_tmr <= n_hold_tmr;
            r_gap_act  <= n_gap_act;
            r_gap_tmr  <= n_gap_tmr;
            r_clicks   <= n_clicks;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pressed       = r_out.pressed;
    assign o_press_event   = r_out.press_event;
    assign o_release_event = r_out.release_event;
    assign o_long_press    = r_out.long_press;
    assign o_click_count   = r_out.click_count;
    assign o_hold_time     = r_out.hold_time;

`ifndef NO_ASSERTIONS
    // an item waiting in the input register is never dropped
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid)
        else $error("input item lost while stalled");

    // events agree with the debounced state
    a_event_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_press_event || o_pressed) &&
                        (!o_release_event || !o_pressed))
        else $error("debounce event disagrees with pressed");

    // a reported click sequence only ends while released and not held
    a_count_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_click_count != '0) |-> !o_pressed && (o_hold_time == '0))
        else $error("click count reported while pressed or held");

    // long press comes on the raw release, so no hold time is shown
    a_long_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_long_press |-> (o_hold_time == '0))
        else $error("long press with nonzero hold time");

    // a debounced change restarts the debounce timer
    a_since_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (n_stable != r_stable) |=> (r_since == '0))
        else $error("debounce timer not cleared on change");
`endif

endmodule

`default_nettype wire
